### hdl/tapt_pkg.sv
// Shared types and constants for the timed actuator position tracker.
// No dependencies; used by tapt_ctrl, tapt_datapath and the top level.
package tapt_pkg;

   localparam int POS_W     = 16;
   localparam int DUR_W     = 24;
   localparam int NUM_W     = DUR_W + POS_W;
   localparam int DIV_STEPS = POS_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W = 2;

   localparam logic [POS_W-1:0] POS_OPEN   = '1;
   localparam logic [POS_W-1:0] POS_CLOSED = '0;
   localparam logic [DUR_W-1:0] DUR_RESET  = 24'd10000;
   localparam logic [DUR_W-1:0] ELAPSED_MAX = '1;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_STOP   = 2'd1,
      OP_TOGGLE = 2'd2,
      OP_GOTO   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      MOT_IDLE    = 2'd0,
      MOT_OPENING = 2'd1,
      MOT_CLOSING = 2'd2
   } motion_type;

   typedef enum logic [1:0] {
      PULSE_NONE  = 2'd0,
      PULSE_STOP  = 2'd1,
      PULSE_OPEN  = 2'd2,
      PULSE_CLOSE = 2'd3
   } pulse_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OPEN_TIME  = 2'd0,
      CSR_CLOSE_TIME = 2'd1,
      CSR_ENDSTOP    = 2'd2,
      CSR_MANUAL     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_FIN,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic prep;
      logic div_step;
      logic finish;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic needs_div;
   } dp_status_type;

endpackage

### hdl/tapt_ctrl.sv
// Controller FSM of the position tracker: handshakes, divider step count.
// Depends on tapt_pkg.
module tapt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  tapt_pkg::dp_status_type status,
   output tapt_pkg::ctrl_cmd_type  cmd
);

   localparam logic [tapt_pkg::DIV_CNT_W-1:0] DIV_LAST =
      tapt_pkg::DIV_CNT_W'(tapt_pkg::DIV_STEPS - 1);

   tapt_pkg::ctrl_state_type state_ff, state_in;
   logic [tapt_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tapt_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         tapt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.needs_div ? tapt_pkg::ST_PREP : tapt_pkg::ST_DONE;
            end
         end
         tapt_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = tapt_pkg::ST_DIV;
         end
         tapt_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = tapt_pkg::ST_FIN;
            end
         end
         tapt_pkg::ST_FIN: begin
            cmd.finish = 1'b1;
            state_in   = tapt_pkg::ST_DONE;
         end
         tapt_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = tapt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tapt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // one transaction in flight
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction accepted while busy");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tapt_pkg::ST_DIV && cnt_ff == DIV_LAST) |=> state_ff == tapt_pkg::ST_FIN)
      else $error("divider did not finish after its last step");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == tapt_pkg::ST_DONE))
      else $error("response raised outside the done state");

endmodule

### hdl/tapt_datapath.sv
// Datapath of the position tracker: config registers, motion state,
// 16-step restoring divider and the response register. Depends on tapt_pkg.
module tapt_datapath #(
   parameter int REPORT_PERIOD_MS = 1000
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [tapt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tapt_pkg::DUR_W-1:0]        csr_wdata,
   input  logic [1:0]                        req_opcode,
   input  logic [tapt_pkg::POS_W-1:0]        req_goal_position,
   input  tapt_pkg::ctrl_cmd_type            cmd,
   output tapt_pkg::dp_status_type           status,
   output logic [tapt_pkg::POS_W-1:0]        rsp_position,
   output logic [1:0]                        rsp_motion,
   output logic [1:0]                        rsp_drive_pulse,
   output logic                              rsp_state_report,
   output logic                              rsp_periodic_report
);

   localparam int TIMER_W = $clog2(REPORT_PERIOD_MS + 1);
   localparam logic [TIMER_W-1:0] PERIOD = TIMER_W'(REPORT_PERIOD_MS);
   localparam int PW = tapt_pkg::POS_W;
   localparam int DW = tapt_pkg::DUR_W;
   localparam int NW = tapt_pkg::NUM_W;

   // configuration
   logic [DW-1:0] open_time_ff, close_time_ff;
   logic          endstop_ff, manual_ff;

   // tracker state
   logic [PW-1:0]           pos_ff, pos_in;
   logic [PW-1:0]           anchor_ff, anchor_in;
   logic [DW-1:0]           elapsed_ff, elapsed_in;
   tapt_pkg::motion_type    motion_ff, motion_in;
   tapt_pkg::motion_type    last_dir_ff, last_dir_in;
   logic [PW-1:0]           target_ff, target_in;
   logic [TIMER_W-1:0]      timer_ff, timer_in;

   // per-transaction result flags
   tapt_pkg::pulse_type     pulse_ff, pulse_in;
   logic                    srep_ff, srep_in;
   logic                    prep_ff, prep_in;

   // divider
   logic [DW-1:0]           rem_ff, rem_in;
   logic [PW-1:0]           numlo_ff, numlo_in;
   logic [PW-1:0]           quo_ff, quo_in;
   logic                    sat_ff, sat_in;

   // response register
   logic [PW-1:0]           rsp_pos_ff;
   tapt_pkg::motion_type    rsp_motion_ff;
   tapt_pkg::pulse_type     rsp_pulse_ff;
   logic                    rsp_srep_ff, rsp_prep_ff;

   tapt_pkg::opcode_type    op;
   logic [DW-1:0]           dur;
   logic                    moving;

   assign op     = tapt_pkg::opcode_type'(req_opcode);
   assign moving = (motion_ff != tapt_pkg::MOT_IDLE);
   assign status.needs_div = (op == tapt_pkg::OP_TICK) && moving;

   always_comb begin
      dur = (motion_ff == tapt_pkg::MOT_OPENING) ? open_time_ff : close_time_ff;
      if (dur == '0) begin
         dur = DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_time_ff  <= tapt_pkg::DUR_RESET;
         close_time_ff <= tapt_pkg::DUR_RESET;
         endstop_ff    <= 1'b0;
         manual_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (tapt_pkg::csr_index_type'(csr_index))
            tapt_pkg::CSR_OPEN_TIME:  open_time_ff  <= csr_wdata;
            tapt_pkg::CSR_CLOSE_TIME: close_time_ff <= csr_wdata;
            tapt_pkg::CSR_ENDSTOP:    endstop_ff    <= csr_wdata[0];
            tapt_pkg::CSR_MANUAL:     manual_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         anchor_ff   <= '0;
         elapsed_ff  <= '0;
         motion_ff   <= tapt_pkg::MOT_IDLE;
         last_dir_ff <= tapt_pkg::MOT_IDLE;
         target_ff   <= '0;
         timer_ff    <= '0;
         pulse_ff    <= tapt_pkg::PULSE_NONE;
         srep_ff     <= 1'b0;
         prep_ff     <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         anchor_ff   <= anchor_in;
         elapsed_ff  <= elapsed_in;
         motion_ff   <= motion_in;
         last_dir_ff <= last_dir_in;
         target_ff   <= target_in;
         timer_ff    <= timer_in;
         pulse_ff    <= pulse_in;
         srep_ff     <= srep_in;
         prep_ff     <= prep_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      numlo_ff <= numlo_in;
      quo_ff   <= quo_in;
      sat_ff   <= sat_in;
      if (cmd.out_load) begin
         rsp_pos_ff    <= pos_ff;
         rsp_motion_ff <= motion_ff;
         rsp_pulse_ff  <= pulse_ff;
         rsp_srep_ff   <= srep_ff;
         rsp_prep_ff   <= prep_ff;
      end
   end

   always_comb begin
      logic                 due;
      logic                 at_end;
      logic                 force_end;
      logic                 do_start;
      logic [PW-1:0]        opp_end;
      logic [PW-1:0]        base_pos;
      tapt_pkg::motion_type new_dir;
      logic [NW-1:0]        num;
      logic [DW:0]          r2;
      logic [DW:0]          diff;
      logic                 ge;
      logic [PW-1:0]        delta;
      logic [PW:0]          sum;
      logic [PW-1:0]        new_pos;
      logic                 hit;

      pos_in      = pos_ff;
      anchor_in   = anchor_ff;
      elapsed_in  = elapsed_ff;
      motion_in   = motion_ff;
      last_dir_in = last_dir_ff;
      target_in   = target_ff;
      timer_in    = timer_ff;
      pulse_in    = pulse_ff;
      srep_in     = srep_ff;
      prep_in     = prep_ff;
      rem_in      = rem_ff;
      numlo_in    = numlo_ff;
      quo_in      = quo_ff;
      sat_in      = sat_ff;

      due       = (timer_ff >= PERIOD);
      at_end    = (req_goal_position == tapt_pkg::POS_OPEN) ||
                  (req_goal_position == tapt_pkg::POS_CLOSED);
      opp_end   = (req_goal_position == tapt_pkg::POS_CLOSED) ?
                  tapt_pkg::POS_OPEN : tapt_pkg::POS_CLOSED;
      force_end = manual_ff && at_end;
      base_pos  = force_end ? opp_end : pos_ff;
      if (req_goal_position == pos_ff) begin
         new_dir  = (req_goal_position == tapt_pkg::POS_CLOSED) ?
                    tapt_pkg::MOT_CLOSING : tapt_pkg::MOT_OPENING;
         do_start = at_end && (manual_ff || endstop_ff);
      end else begin
         new_dir  = (req_goal_position < pos_ff) ?
                    tapt_pkg::MOT_CLOSING : tapt_pkg::MOT_OPENING;
         do_start = 1'b1;
      end

      num  = {elapsed_ff, PW'(0)} - NW'(elapsed_ff);
      r2   = {rem_ff, numlo_ff[PW-1]};
      diff = r2 - {1'b0, dur};
      ge   = (r2 >= {1'b0, dur});

      delta = sat_ff ? tapt_pkg::POS_OPEN : quo_ff;
      sum   = {1'b0, anchor_ff} + {1'b0, delta};
      if (motion_ff == tapt_pkg::MOT_OPENING) begin
         new_pos = sum[PW] ? tapt_pkg::POS_OPEN : sum[PW-1:0];
         hit     = (new_pos >= target_ff);
      end else begin
         new_pos = (delta >= anchor_ff) ? tapt_pkg::POS_CLOSED : (anchor_ff - delta);
         hit     = (new_pos <= target_ff);
      end

      if (cmd.accept) begin
         pulse_in = tapt_pkg::PULSE_NONE;
         srep_in  = 1'b0;
         prep_in  = 1'b0;
         unique case (op)
            tapt_pkg::OP_TICK: begin
               if (due && moving) begin
                  timer_in = '0;
               end else if (!due) begin
                  timer_in = timer_ff + 1'b1;
               end
               if (moving) begin
                  if (elapsed_ff != tapt_pkg::ELAPSED_MAX) begin
                     elapsed_in = elapsed_ff + 1'b1;
                  end
                  prep_in = due;
               end
            end
            tapt_pkg::OP_STOP: begin
               pulse_in   = tapt_pkg::PULSE_STOP;
               motion_in  = tapt_pkg::MOT_IDLE;
               anchor_in  = pos_ff;
               elapsed_in = '0;
               srep_in    = 1'b1;
            end
            tapt_pkg::OP_TOGGLE: begin
               anchor_in  = pos_ff;
               elapsed_in = '0;
               if (moving) begin
                  pulse_in  = tapt_pkg::PULSE_STOP;
                  motion_in = tapt_pkg::MOT_IDLE;
                  srep_in   = 1'b1;
               end else if (pos_ff == tapt_pkg::POS_CLOSED ||
                            last_dir_ff == tapt_pkg::MOT_CLOSING) begin
                  target_in   = tapt_pkg::POS_OPEN;
                  last_dir_in = tapt_pkg::MOT_OPENING;
                  pulse_in    = tapt_pkg::PULSE_OPEN;
                  motion_in   = tapt_pkg::MOT_OPENING;
               end else begin
                  target_in   = tapt_pkg::POS_CLOSED;
                  last_dir_in = tapt_pkg::MOT_CLOSING;
                  pulse_in    = tapt_pkg::PULSE_CLOSE;
                  motion_in   = tapt_pkg::MOT_CLOSING;
               end
            end
            tapt_pkg::OP_GOTO: begin
               // manual mode with an end as goal: trust nothing, restart from the far end
               if (force_end) begin
                  pos_in     = opp_end;
                  anchor_in  = opp_end;
                  elapsed_in = '0;
               end
               if (do_start) begin
                  target_in = req_goal_position;
                  if (new_dir != motion_ff) begin
                     last_dir_in = new_dir;
                     motion_in   = new_dir;
                     pulse_in    = (new_dir == tapt_pkg::MOT_OPENING) ?
                                   tapt_pkg::PULSE_OPEN : tapt_pkg::PULSE_CLOSE;
                     anchor_in   = base_pos;
                     elapsed_in  = '0;
                  end
               end
            end
            default: ;
         endcase
      end

      // delta = elapsed * 65535 / dur; a quotient past 16 bits saturates
      if (cmd.prep) begin
         sat_in   = (num >= {dur, PW'(0)});
         rem_in   = num[NW-1:PW];
         numlo_in = num[PW-1:0];
         quo_in   = '0;
      end

      if (cmd.div_step) begin
         rem_in   = ge ? diff[DW-1:0] : r2[DW-1:0];
         numlo_in = {numlo_ff[PW-2:0], 1'b0};
         quo_in   = {quo_ff[PW-2:0], ge};
      end

      if (cmd.finish) begin
         pos_in = new_pos;
         if (hit) begin
            motion_in  = tapt_pkg::MOT_IDLE;
            anchor_in  = new_pos;
            elapsed_in = '0;
            srep_in    = 1'b1;
            if (!(endstop_ff && (target_ff == tapt_pkg::POS_OPEN ||
                                 target_ff == tapt_pkg::POS_CLOSED))) begin
               pulse_in = tapt_pkg::PULSE_STOP;
            end
         end
      end
   end

   assign rsp_position        = rsp_pos_ff;
   assign rsp_motion          = rsp_motion_ff;
   assign rsp_drive_pulse     = rsp_pulse_ff;
   assign rsp_state_report    = rsp_srep_ff;
   assign rsp_periodic_report = rsp_prep_ff;

   a_idle_no_run: assert property (@(posedge clock) disable iff (reset)
      (motion_ff == tapt_pkg::MOT_IDLE) |-> (elapsed_ff == '0))
      else $error("run time counting while idle");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && !sat_ff) |-> (rem_ff < dur))
      else $error("divider remainder out of range");

   a_report_stops: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish ##1 srep_ff) |-> (motion_ff == tapt_pkg::MOT_IDLE))
      else $error("target reached but motor still running");

endmodule

### hdl/timed_actuator_position_tracker.sv
// Stop, toggle, go-to and idle ticks go from acceptance straight to the output
// load; a tick while moving runs setup, 16 restoring divider steps, finish and
// output load. The output load waits while an earlier response is not taken.
// One transaction is in work at a time; the divider gives one bit per cycle.
// Reset (synchronous, active high) gives closed and idle, durations of 10000 ms,
// both modes off; an item is accepted while the previous response still waits.
module timed_actuator_position_tracker #(
   parameter int REPORT_PERIOD_MS = 1000
) (
   input  logic        clock,
   input  logic        reset,
   // configuration write port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_goal_position,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_position,
   output logic [1:0]  rsp_motion,
   output logic [1:0]  rsp_drive_pulse,
   output logic        rsp_state_report,
   output logic        rsp_periodic_report
);

   // Controller and datapath talk only through these two bundles.
   //   status.needs_div: the offered transaction is a tick while the motor
   //                     runs, so the position has to be recomputed.
   //   cmd.accept:       apply the transaction to the tracker state.
   //   cmd.prep/div_step/finish: run the elapsed*65535/duration division
   //                     and check whether the target has been reached.
   //   cmd.out_load:     copy the result into the response register.
   tapt_pkg::ctrl_cmd_type  cmd;
   tapt_pkg::dp_status_type status;

   tapt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath keeps position as unsigned 0.16 and derives it from the
   // anchor plus or minus the run time scaled by the active travel duration.
   // Quotients of 65536 or more are caught before dividing and saturate the
   // result, which keeps the divider at 16 steps.
   tapt_datapath #(
      .REPORT_PERIOD_MS (REPORT_PERIOD_MS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_opcode          (req_opcode),
      .req_goal_position   (req_goal_position),
      .cmd                 (cmd),
      .status              (status),
      .rsp_position        (rsp_position),
      .rsp_motion          (rsp_motion),
      .rsp_drive_pulse     (rsp_drive_pulse),
      .rsp_state_report    (rsp_state_report),
      .rsp_periodic_report (rsp_periodic_report)
   );

endmodule
